/* rtl/core/chlg_pkg.sv */
// shared types, constants and microcode for the core hotplug load governor
`timescale 1ns / 1ps
`default_nettype none
package chlg_pkg;

  localparam int MAX_CORES_DEF   = 4;
  localparam int TICKS_DEF       = 100;

  localparam int LOAD_W          = 10;
  localparam int TIME_W          = 32;
  localparam int LEVEL_W         = 8;
  localparam int HOLD_W          = 16;
  localparam int PRESENT_W       = 3;
  localparam int CMD_W           = 2;
  localparam int MASK_OUT_W      = 4;
  localparam int DELAY_W         = 10;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;
  localparam int IN_DATA_W       = 48;
  localparam int OUT_DATA_W      = 16;

  localparam logic [LEVEL_W-1:0]   HIGH_RST    = 8'd70;
  localparam logic [LEVEL_W-1:0]   MID_RST     = 8'd40;
  localparam logic [LEVEL_W-1:0]   LOW_RST     = 8'd20;
  localparam logic [HOLD_W-1:0]    HOLD_RST    = 16'd2000;
  localparam logic [PRESENT_W-1:0] PRESENT_RST = 3'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE,
    CMD_SUSPEND,
    CMD_RESUME,
    CMD_NOP
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH,
    CFG_MID,
    CFG_LOW,
    CFG_HOLD,
    CFG_PRESENT
  } cfg_idx_t;

  typedef enum logic [2:0] {
    STEP_FETCH,
    STEP_SMP_COUNT,
    STEP_SMP_EVAL,
    STEP_SMP_APPLY,
    STEP_SUSPEND,
    STEP_RESUME,
    STEP_NOP_COUNT,
    STEP_REPORT
  } step_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_SAMPLE,
    ACT_SUSPEND,
    ACT_RESUME
  } act_t;

  typedef enum logic [1:0] {
    DLY_ZERO,
    DLY_PERIOD,
    DLY_FULL
  } dly_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_IF_ASLEEP,
    JMP_DISPATCH
  } jmp_t;

  typedef struct packed {
    logic  wait_in;
    logic  ld_n;
    logic  ld_eval;
    act_t  act;
    dly_t  dly;
    logic  emit;
    jmp_t  jmp;
    step_t target;
  } cword_t;

  typedef struct packed {
    cword_t cw;
    logic   go;
  } seq_ctrl_t;

  typedef struct packed {
    logic asleep;
    logic out_free;
  } dp_stat_t;

  function automatic cword_t ucode(input step_t pc);
    cword_t w;
    w = '{wait_in: 1'b0, ld_n: 1'b0, ld_eval: 1'b0, act: ACT_NONE, dly: DLY_ZERO,
          emit: 1'b0, jmp: JMP_NEXT, target: STEP_FETCH};
    unique case (pc)
      STEP_FETCH: begin
        w.wait_in = 1'b1;
        w.jmp     = JMP_DISPATCH;
      end
      STEP_SMP_COUNT: begin
        w.ld_n   = 1'b1;
        w.jmp    = JMP_IF_ASLEEP;
        w.target = STEP_REPORT;
      end
      STEP_SMP_EVAL: begin
        w.ld_eval = 1'b1;
      end
      STEP_SMP_APPLY: begin
        w.act  = ACT_SAMPLE;
        w.dly  = DLY_PERIOD;
        w.emit = 1'b1;
        w.jmp  = JMP_ALWAYS;
      end
      STEP_SUSPEND: begin
        w.act  = ACT_SUSPEND;
        w.emit = 1'b1;
        w.jmp  = JMP_ALWAYS;
      end
      STEP_RESUME: begin
        w.act  = ACT_RESUME;
        w.dly  = DLY_FULL;
        w.emit = 1'b1;
        w.jmp  = JMP_ALWAYS;
      end
      STEP_NOP_COUNT: begin
        w.ld_n = 1'b1;
      end
      STEP_REPORT: begin
        w.dly  = DLY_PERIOD;
        w.emit = 1'b1;
        w.jmp  = JMP_ALWAYS;
      end
    endcase
    return w;
  endfunction

  function automatic step_t dispatch(input cmd_t cmd);
    step_t s;
    unique case (cmd)
      CMD_SAMPLE:  s = STEP_SMP_COUNT;
      CMD_SUSPEND: s = STEP_SUSPEND;
      CMD_RESUME:  s = STEP_RESUME;
      CMD_NOP:     s = STEP_NOP_COUNT;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/chlg_seq.sv */
// microcode sequencer: step counter, control rom and jumps
`timescale 1ns / 1ps
`default_nettype none
module chlg_seq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  input  wire logic [chlg_pkg::CMD_W-1:0]    cmd,
  input  wire chlg_pkg::dp_stat_t            stat,
  output chlg_pkg::seq_ctrl_t                ctrl
);

  chlg_pkg::step_t  pc;
  chlg_pkg::step_t  pc_next;
  chlg_pkg::cword_t cw;
  logic             go;

  assign cw = chlg_pkg::ucode(pc);

  always_comb begin
    if (cw.wait_in) begin
      go = s_tvalid;
    end else if (cw.emit) begin
      go = stat.out_free;
    end else begin
      go = 1'b1;
    end
  end

  always_comb begin
    pc_next = pc;
    if (go) begin
      unique case (cw.jmp)
        chlg_pkg::JMP_NEXT:      pc_next = chlg_pkg::step_t'(pc + 3'd1);
        chlg_pkg::JMP_ALWAYS:    pc_next = cw.target;
        chlg_pkg::JMP_IF_ASLEEP: begin
          pc_next = stat.asleep ? cw.target : chlg_pkg::step_t'(pc + 3'd1);
        end
        chlg_pkg::JMP_DISPATCH:  pc_next = chlg_pkg::dispatch(chlg_pkg::cmd_t'(cmd));
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= chlg_pkg::STEP_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctrl.cw = cw;
  assign ctrl.go = go;

  a_emit_returns: assert property (@(posedge clk) disable iff (rst)
    (cw.emit && go) |=> pc == chlg_pkg::STEP_FETCH)
    else $error("sequencer did not return to fetch after a result");

  a_fetch_leaves: assert property (@(posedge clk) disable iff (rst)
    (cw.wait_in && go) |=> pc != chlg_pkg::STEP_FETCH)
    else $error("accepted transaction was not dispatched");

  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    (cw.emit && go) |-> stat.out_free)
    else $error("result issued while output register full");

endmodule
`default_nettype wire

/* rtl/core/chlg_dp.sv */
// datapath: config registers, governor state, evaluation and output register
`timescale 1ns / 1ps
`default_nettype none
module chlg_dp #(
  parameter int MAX_CORES        = chlg_pkg::MAX_CORES_DEF,
  parameter int TICKS_PER_SECOND = chlg_pkg::TICKS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire chlg_pkg::seq_ctrl_t                ctrl,
  output chlg_pkg::dp_stat_t                      stat,
  input  wire logic [chlg_pkg::LOAD_W-1:0]        load,
  input  wire logic [chlg_pkg::TIME_W-1:0]        now_ms,
  input  wire logic                               cfg_valid,
  input  wire logic [chlg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [chlg_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [chlg_pkg::MASK_OUT_W-1:0]         online_mask,
  output logic                                    freq_capped,
  output logic [chlg_pkg::DELAY_W-1:0]            next_delay_ticks
);

  localparam int CW     = $clog2(MAX_CORES + 1);
  localparam int IW     = $clog2(MAX_CORES);
  localparam int PW     = chlg_pkg::TIME_W + CW;
  localparam int LW     = chlg_pkg::LEVEL_W + CW;
  localparam int RST_N  = (int'(chlg_pkg::PRESENT_RST) > MAX_CORES) ?
                          MAX_CORES : int'(chlg_pkg::PRESENT_RST);
  localparam logic [MAX_CORES-1:0] RST_MASK = MAX_CORES'((1 << RST_N) - 1);

  logic [chlg_pkg::LEVEL_W-1:0]   high_lvl;
  logic [chlg_pkg::LEVEL_W-1:0]   mid_lvl;
  logic [chlg_pkg::LEVEL_W-1:0]   low_lvl;
  logic [chlg_pkg::HOLD_W-1:0]    hold_ms;
  logic [chlg_pkg::PRESENT_W-1:0] present;

  logic [MAX_CORES-1:0]           core_mask;
  logic [chlg_pkg::TIME_W-1:0]    last_change_ms;
  logic                           asleep;
  logic                           cap_on;

  logic [chlg_pkg::LOAD_W-1:0]    load_q;
  logic [chlg_pkg::TIME_W-1:0]    now_q;
  logic [CW-1:0]                  n_q;
  logic [chlg_pkg::TIME_W-1:0]    elapsed_q;
  logic                           due_q;
  logic                           hi_q;
  logic                           mid_q;
  logic                           lo_q;

  logic [CW-1:0]                  online_cnt;
  logic [CW-1:0]                  p_eff;
  logic [3:0]                     present4;
  logic [MAX_CORES-1:0]           pmask;
  logic [MAX_CORES-1:0]           first_off;
  logic                           found;
  logic [PW-1:0]                  scaled;
  logic [LW-1:0]                  hi_lim;
  logic [LW-1:0]                  mid_lim;
  logic [LW-1:0]                  lo_lim;
  logic [LW-1:0]                  load_x;

  logic [MAX_CORES-1:0]           mask_new;
  logic [chlg_pkg::TIME_W-1:0]    last_new;
  logic                           asleep_new;
  logic                           cap_new;
  logic [chlg_pkg::DELAY_W-1:0]   delay_new;
  logic [chlg_pkg::MASK_OUT_W-1:0] mask_out;
  logic [chlg_pkg::DELAY_W-1:0]   period_tbl [MAX_CORES];

  // ticks per sample for each online count
  for (genvar g = 0; g < MAX_CORES; g++) begin : g_period
    localparam int PER = TICKS_PER_SECOND / (g + 1);
    assign period_tbl[g] = chlg_pkg::DELAY_W'(PER);
  end

  for (genvar g = 0; g < chlg_pkg::MASK_OUT_W; g++) begin : g_mask_out
    if (g < MAX_CORES) begin : g_on
      assign mask_out[g] = mask_new[g];
    end else begin : g_off
      assign mask_out[g] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_lvl <= chlg_pkg::HIGH_RST;
      mid_lvl  <= chlg_pkg::MID_RST;
      low_lvl  <= chlg_pkg::LOW_RST;
      hold_ms  <= chlg_pkg::HOLD_RST;
      present  <= chlg_pkg::PRESENT_RST;
    end else if (cfg_valid) begin
      unique case (chlg_pkg::cfg_idx_t'(cfg_index))
        chlg_pkg::CFG_HIGH:    high_lvl <= cfg_data[chlg_pkg::LEVEL_W-1:0];
        chlg_pkg::CFG_MID:     mid_lvl  <= cfg_data[chlg_pkg::LEVEL_W-1:0];
        chlg_pkg::CFG_LOW:     low_lvl  <= cfg_data[chlg_pkg::LEVEL_W-1:0];
        chlg_pkg::CFG_HOLD:    hold_ms  <= cfg_data[chlg_pkg::HOLD_W-1:0];
        chlg_pkg::CFG_PRESENT: present  <= cfg_data[chlg_pkg::PRESENT_W-1:0];
        default: ;
      endcase
    end
  end

  // present count clamped to 1..MAX_CORES, and its mask
  always_comb begin
    present4 = {1'b0, present};
    if (present == '0) begin
      p_eff = CW'(1);
    end else if (present4 > 4'(MAX_CORES)) begin
      p_eff = CW'(MAX_CORES);
    end else begin
      p_eff = CW'(present);
    end
    for (int i = 0; i < MAX_CORES; i++) begin
      pmask[i] = (i == 0) || (CW'(i) < p_eff);
    end
  end

  always_comb begin
    online_cnt = '0;
    for (int i = 0; i < MAX_CORES; i++) begin
      online_cnt = online_cnt + CW'(core_mask[i]);
    end
  end

  // lowest offline present core above core 0
  always_comb begin
    found     = 1'b0;
    first_off = '0;
    for (int i = 1; i < MAX_CORES; i++) begin
      if (!found && !core_mask[i] && (CW'(i) < p_eff)) begin
        first_off[i] = 1'b1;
        found        = 1'b1;
      end
    end
  end

  // hold/n <= elapsed  <=>  hold <= n*elapsed + n - 1
  assign scaled  = PW'(elapsed_q) * PW'(n_q) + PW'(n_q) - PW'(1);
  assign hi_lim  = LW'(high_lvl) * LW'(n_q);
  assign mid_lim = LW'(mid_lvl) * LW'(n_q);
  assign lo_lim  = LW'(low_lvl) * LW'(n_q);
  assign load_x  = LW'(load_q);

  always_ff @(posedge clk) begin
    if (ctrl.cw.wait_in && ctrl.go) begin
      load_q <= load;
      now_q  <= now_ms;
    end
    if (ctrl.cw.ld_n) begin
      n_q       <= online_cnt;
      elapsed_q <= now_q - last_change_ms;
    end
    if (ctrl.cw.ld_eval) begin
      due_q <= scaled >= PW'(hold_ms);
      hi_q  <= (load_x >= hi_lim) && (n_q < p_eff);
      mid_q <= (load_x >= mid_lim) && (n_q < p_eff);
      lo_q  <= (load_x <= lo_lim) && (n_q > CW'(1));
    end
  end

  always_comb begin
    mask_new   = core_mask;
    last_new   = last_change_ms;
    asleep_new = asleep;
    cap_new    = cap_on;
    unique case (ctrl.cw.act)
      chlg_pkg::ACT_NONE: ;
      chlg_pkg::ACT_SAMPLE: begin
        priority if (hi_q) begin
          if (due_q) begin
            mask_new = core_mask | pmask;
            last_new = now_q;
          end
        end else if (mid_q) begin
          if (due_q) begin
            mask_new = core_mask | first_off;
            last_new = now_q;
          end
        end else if (lo_q) begin
          if (due_q) begin
            mask_new = MAX_CORES'(1);
            last_new = now_q;
          end
        end
      end
      chlg_pkg::ACT_SUSPEND: begin
        mask_new   = MAX_CORES'(1);
        asleep_new = 1'b1;
        cap_new    = 1'b1;
      end
      chlg_pkg::ACT_RESUME: begin
        mask_new   = core_mask | pmask;
        asleep_new = 1'b0;
        cap_new    = 1'b0;
        last_new   = now_q;
      end
    endcase
    mask_new[0] = 1'b1;
  end

  always_comb begin
    unique case (ctrl.cw.dly)
      chlg_pkg::DLY_PERIOD: delay_new = asleep ? '0 : period_tbl[IW'(n_q - CW'(1))];
      chlg_pkg::DLY_FULL:   delay_new = chlg_pkg::DELAY_W'(TICKS_PER_SECOND);
      default:              delay_new = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      core_mask      <= RST_MASK;
      last_change_ms <= '0;
      asleep         <= 1'b0;
      cap_on         <= 1'b0;
    end else if (ctrl.go && ctrl.cw.act != chlg_pkg::ACT_NONE) begin
      core_mask      <= mask_new;
      last_change_ms <= last_new;
      asleep         <= asleep_new;
      cap_on         <= cap_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.go && ctrl.cw.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.go && ctrl.cw.emit) begin
      online_mask      <= mask_out;
      freq_capped      <= cap_new;
      next_delay_ticks <= delay_new;
    end
  end

  assign stat.asleep   = asleep;
  assign stat.out_free = !m_tvalid || m_tready;

  a_core0_online: assert property (@(posedge clk) disable iff (rst)
    core_mask[0])
    else $error("core 0 went offline");

  a_cap_tracks_sleep: assert property (@(posedge clk) disable iff (rst)
    asleep == cap_on)
    else $error("frequency cap and suspend flag disagree");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (ctrl.go && ctrl.cw.emit) |=> m_tvalid)
    else $error("issued result not presented");

endmodule
`default_nettype wire

/* rtl/core/core_hotplug_load_governor_unit.sv */
// top level of the core hotplug load governor
`timescale 1ns / 1ps
`default_nettype none
// Each input transaction carries a command in s_tuser (load sample, suspend, resume, no-op)
// with the load and millisecond time in s_tdata, and yields exactly one result transaction
// holding the online core mask, the frequency cap flag and the next sampling delay. One
// transaction is in work at a time, stepped through by a small microprogram: a load sample
// steps through fetch, count online cores, evaluate thresholds and hold time, and apply, its
// result registered when the apply step issues it; a sample while suspended and a no-op
// command step through fetch, count and report, suspend and resume through fetch and apply,
// and a step issuing a result stalls while the output register is full and m_tready is low.
// The next transaction can be accepted in the cycle after the result is issued. The
// hold-time check is made as a multiply-and-compare, so no divider is needed.
// Configuration writes are always accepted and should be made while the block is idle.
module core_hotplug_load_governor_unit #(
  parameter int MAX_CORES        = chlg_pkg::MAX_CORES_DEF,
  parameter int TICKS_PER_SECOND = chlg_pkg::TICKS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // load [9:0], now_ms [41:10], zero fill [47:42]
  input  wire logic [chlg_pkg::IN_DATA_W-1:0]     s_tdata,
  // cmd [1:0]
  input  wire logic [chlg_pkg::CMD_W-1:0]         s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // online_mask [3:0], freq_capped [4], next_delay_ticks [14:5], zero fill [15]
  output logic [chlg_pkg::OUT_DATA_W-1:0]         m_tdata,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [chlg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [chlg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  chlg_pkg::seq_ctrl_t                ctrl;
  chlg_pkg::dp_stat_t                 stat;
  logic [chlg_pkg::MASK_OUT_W-1:0]    online_mask;
  logic                               freq_capped;
  logic [chlg_pkg::DELAY_W-1:0]       next_delay_ticks;

  chlg_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .cmd      (s_tuser),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  chlg_dp #(
    .MAX_CORES        (MAX_CORES),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (ctrl),
    .stat             (stat),
    .load             (s_tdata[chlg_pkg::LOAD_W-1:0]),
    .now_ms           (s_tdata[chlg_pkg::LOAD_W +: chlg_pkg::TIME_W]),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .online_mask      (online_mask),
    .freq_capped      (freq_capped),
    .next_delay_ticks (next_delay_ticks)
  );

  assign s_tready  = ctrl.cw.wait_in;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {1'b0, next_delay_ticks, freq_capped, online_mask};

endmodule
`default_nettype wire
